### design/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the stream group reverser.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_W   = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic                      item_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

### design/sgr_group_mem.sv
// ----------------------------------------------------------------------------
// sgr_group_mem
// Group buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sgr_group_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [sgr_pkg::VALUE_W-1:0] wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic signed [sgr_pkg::VALUE_W-1:0] rdata
);
  import sgr_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low; it doubles as the output register
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/stream_group_reverser.sv
// ----------------------------------------------------------------------------
// stream_group_reverser
// Collects values into a group buffer and replays each full group in
// reverse order; a partial group at the end of a sequence replays in order.
// ----------------------------------------------------------------------------
//
//   channel  | ports                      | direction | accepted when
//   ---------+----------------------------+-----------+-------------------------
//   input    | in_valid/in_ready/in_item  | in        | in_valid && in_ready
//   result   | out_valid/out_ready/out_item| out      | out_valid && out_ready
//   config   | cfg_we/cfg_wdata           | in        | cfg_we
//
// An item that does not close a group is only written to the buffer. An item
// that closes a group of n values is written, then drained with one buffer read
// per result, since the single read port of the group buffer is the limit.
// Output stalls freeze the drain; the read-data register is the output
// register, so the next item is taken while the final result waits.
// Synchronous active-low reset empties the group and sets group size 1;
// buffer contents are not cleared.
// ----------------------------------------------------------------------------
module stream_group_reverser #(
  parameter int unsigned GROUP_MAX = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgr_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sgr_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [sgr_pkg::CFG_W-1:0] cfg_wdata
);
  import sgr_pkg::*;

  localparam int unsigned AW = $clog2(GROUP_MAX);     // buffer address
  localparam int unsigned CW = $clog2(GROUP_MAX + 1); // counts 0..GROUP_MAX

  state_t         state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [CW-1:0]  remain_r, remain_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic           rev_r, rev_nxt;
  logic           last_r, last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_last_r, out_last_nxt;

  logic [CW-1:0]  k_eff;
  logic [CW-1:0]  n_cnt;
  logic           in_acc;
  logic           rd_en;
  logic signed [VALUE_W-1:0] rdata;

  // group size: zero acts as one, anything above the buffer depth saturates
  always_comb begin
    if (cfg_r == '0) begin
      k_eff = CW'(1);
    end else if (32'(cfg_r) > GROUP_MAX) begin
      k_eff = CW'(GROUP_MAX);
    end else begin
      k_eff = CW'(cfg_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign n_cnt    = fill_r + CW'(1);

  // one buffer read per result, only when the output slot is free or leaving
  assign rd_en = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    remain_nxt    = remain_r;
    idx_nxt       = idx_r;
    rev_nxt       = rev_r;
    last_nxt      = last_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_item.item_last;
          if (n_cnt >= k_eff) begin
            // full group: replay newest first
            state_nxt  = ST_DRAIN;
            rev_nxt    = 1'b1;
            idx_nxt    = fill_r[AW-1:0];
            remain_nxt = n_cnt;
            fill_nxt   = '0;
          end else if (in_item.item_last) begin
            // partial group at end of sequence: replay in arrival order
            state_nxt  = ST_DRAIN;
            rev_nxt    = 1'b0;
            idx_nxt    = '0;
            remain_nxt = n_cnt;
            fill_nxt   = '0;
          end else begin
            fill_nxt = n_cnt;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_en) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_r && (remain_r == CW'(1));
          idx_nxt       = rev_r ? idx_r - AW'(1) : idx_r + AW'(1);
          remain_nxt    = remain_r - CW'(1);
          if (remain_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_W'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    remain_r   <= remain_nxt;
    idx_r      <= idx_nxt;
    rev_r      <= rev_nxt;
    last_r     <= last_nxt;
    out_last_r <= out_last_nxt;
  end

  // write lands at the accept edge; the drain's first read waits for state_r to
  // show ST_DRAIN, so the FSM itself keeps reads and writes of one entry apart
  sgr_group_mem #(
    .DEPTH (GROUP_MAX)
  ) u_mem (
    .clk   (clk),
    .we    (in_acc),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_item.item_value),
    .re    (rd_en),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_item.out_value = rdata;
  assign out_item.out_last  = out_last_r;

endmodule

### design/sgr_checker.sv
// ----------------------------------------------------------------------------
// sgr_checker
// Port-level checks for the stream group reverser.
// ----------------------------------------------------------------------------
module sgr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sgr_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input sgr_pkg::out_item_t out_item
);
  import sgr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // end of sequence always flushes the group
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.item_last |=> !in_ready)
    else $error("last item did not start a flush");

  // a shown result carries no unknown bits
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_item))
    else $error("result carries unknown bits");

endmodule

bind stream_group_reverser sgr_checker u_sgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### sim/stream_group_reverser_tb.sv
// ----------------------------------------------------------------------------
// stream_group_reverser_tb
// Self-checking bench for the stream group reverser. A behavioral model of the
// group buffer predicts every result. A checker compares each accepted result
// with the oldest prediction, field by field. Directed items cover the value
// extremes and the group size corner cases. Random sequences run under several
// group sizes. One stretch of output back-pressure fills the block.
// ----------------------------------------------------------------------------
module stream_group_reverser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgr_pkg::*;

  localparam int unsigned GROUP_MAX     = 16;
  localparam int unsigned SETTLE_CYCLES = 4;   // lets a no-result item land
  localparam int unsigned TAIL_CYCLES   = 40;  // > one full-group drain
  localparam int unsigned MAX_GAP       = 15;
  localparam int unsigned HOLD_CYCLES   = 300; // long sink hold-off
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 36;
  localparam int unsigned PRESSURE_ITEMS = 48;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  // DUT ports; every input is known from time zero.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Idle controls for the sender and for the result sink.
  bit                   src_idle = 1'b0;
  bit                   sink_idle = 1'b0;
  int unsigned          sink_hold_cycles = 0;

  // Model of the group buffer.
  logic signed [VALUE_W-1:0] held_values [GROUP_MAX];
  int unsigned          held_count = 0;
  logic [CFG_W-1:0]     group_size_model = 5'd1;

  out_item_t            reordered_q [$];
  int unsigned          mismatch_count = 0;

  stream_group_reverser #(
    .GROUP_MAX (GROUP_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction: hold each value, and flush the group once it is full (reversed)
  // or once the sequence ends (in arrival order).
  // --------------------------------------------------------------------------
  function automatic void reorder_value(in_item_t it);
    int unsigned k;
    int unsigned n;
    out_item_t   r;
    // Size 0 acts as pass-through, sizes past the buffer depth saturate.
    if (group_size_model == '0) k = 1;
    else if (group_size_model > GROUP_MAX) k = GROUP_MAX;
    else k = 32'(group_size_model);
    if (held_count >= GROUP_MAX) held_count = GROUP_MAX - 1;
    held_values[held_count] = it.item_value;
    held_count++;
    n = held_count;
    // A group that already holds at least k values (size lowered while a group
    // was open) flushes everything it holds, reversed.
    if (n >= k || it.item_last) begin
      for (int unsigned i = 0; i < n; i++) begin
        r.out_value = (n >= k) ? held_values[n-1-i] : held_values[i];
        r.out_last  = it.item_last && (i == n - 1);
        reordered_q.push_back(r);
      end
      held_count = 0;
    end
  endfunction

  // Mostly random values, with the two extremes showing up now and then.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        return VALUE_MIN;
      end
      1: begin
        return VALUE_MAX;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one item per call. Valid stays high across back-to-back items and
  // is only lowered for a drawn gap or by wait_idle.
  // --------------------------------------------------------------------------
  task automatic send_item(logic signed [VALUE_W-1:0] value, logic last);
    int unsigned gap;
    in_item_t    it;
    it.item_value = value;
    it.item_last  = last;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    reorder_value(it);
  endtask

  // Block is idle once every predicted result is back and the last input item
  // has had time to land in the buffer.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (reordered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_size(logic [CFG_W-1:0] size);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    group_size_model = size;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: a random stall before each result when sink_idle is set, plus
  // an optional long hold-off requested by the back-pressure test.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (sink_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (reordered_q.size() == 0) begin
        $error("unexpected result: out_value=%0d out_last=%0b",
               out_item.out_value, out_item.out_last);
        mismatch_count++;
      end else begin
        exp_item = reordered_q.pop_front();
        if (out_item.out_value !== exp_item.out_value) begin
          $error("out_value: expected %0d, got %0d",
                 exp_item.out_value, out_item.out_value);
          mismatch_count++;
        end
        if (out_item.out_last !== exp_item.out_last) begin
          $error("out_last: expected %0b, got %0b",
                 exp_item.out_last, out_item.out_last);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset size is 1: every value passes straight through.
  task automatic test_pass_through();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_item(VALUE_MAX, 1'b0);
    send_item(VALUE_MIN, 1'b1);
    send_item(-32'sd1, 1'b0);
  endtask

  // Full group reversed, partial group at the end in order, and a full group
  // closed by the final value.
  task automatic test_group_reversal();
    write_group_size(5'd3);
    send_item(32'sd1, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd4, 1'b1);
    write_group_size(5'd2);
    send_item(VALUE_MAX, 1'b0);
    send_item(VALUE_MIN, 1'b1);
  endtask

  // Size zero acts as 1; the largest register value saturates to the depth.
  task automatic test_size_limits();
    write_group_size(5'd0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd6, 1'b1);
    write_group_size(5'd31);
    for (int unsigned i = 0; i < GROUP_MAX; i++) begin
      send_item(pick_value(), i == GROUP_MAX - 1);
    end
  endtask

  // Open group of three, size then drops to two: the next value flushes all.
  task automatic test_size_lowered();
    write_group_size(5'd5);
    send_item(32'sd10, 1'b0);
    send_item(32'sd11, 1'b0);
    send_item(32'sd12, 1'b0);
    write_group_size(5'd2);
    send_item(32'sd13, 1'b0);
  endtask

  // Random sequences under a spread of sizes. Some sequences lack the final
  // flag and a phase may end mid-group, so open groups meet new sizes.
  task automatic test_random_sequences();
    logic [CFG_W-1:0] size;
    int unsigned      eff;
    int unsigned      sent;
    int unsigned      len;
    bit               last;
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: size = 5'd16;
        1: size = 5'd31;
        2: size = 5'd0;
        3: size = 5'd17;
        4: size = 5'd1;
        5: size = 5'd2;
        default: size = CFG_W'($urandom_range(0, 31));
      endcase
      write_group_size(size);
      eff = (size == 0) ? 1 : (size > GROUP_MAX) ? GROUP_MAX : size;
      // One phase runs flat out on both sides.
      src_idle  = (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      sink_idle = (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 2 * eff + 2);
        for (int unsigned j = 0; j < len && sent < PHASE_ITEMS; j++) begin
          last = (j == len - 1) && ($urandom_range(0, 7) != 0);
          send_item(pick_value(), last);
          sent++;
        end
      end
    end
  endtask

  // Sink holds off for a long stretch while the source keeps streaming full
  // groups, so the block backs up and drops in_ready.
  task automatic test_output_backpressure();
    write_group_size(5'd16);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold_cycles = HOLD_CYCLES;
    for (int unsigned i = 0; i < PRESSURE_ITEMS; i++) begin
      send_item(pick_value(), i == PRESSURE_ITEMS - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pass_through();
    test_group_reversal();
    test_size_limits();
    test_size_lowered();
    test_random_sequences();
    test_output_backpressure();

    wait_idle();
    // catch any stray results after the last prediction is consumed
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
